/* sv/osst_pkg.sv */
// Package for the ordered set successor table.
// Holds capacity constants, request kind codes and controller/datapath structs.
package osst_pkg;
    localparam int unsigned Capacity = 1024;
    localparam int unsigned AddrW = $clog2(Capacity);
    localparam int unsigned CountW = $clog2(Capacity + 1);

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_DELETE = 3'd1;
    localparam logic [2:0] KIND_EXISTS = 3'd2;
    localparam logic [2:0] KIND_NEXT = 3'd3;
    localparam logic [2:0] KIND_PREV = 3'd4;

    typedef struct packed {
        logic load;
        logic srch_init;
        logic srch_rd;
        logic srch_step;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic fin_rd;
        logic fin_load;
        logic wr_key;
        logic cnt_inc;
        logic cnt_dec;
    } t_cmd;

    typedef struct packed {
        logic srch_done;
        logic shift_done;
        logic hit;
        logic full;
        logic [2:0] kind;
    } t_sts;
endpackage

/* sv/osst_if.sv */
// Valid/ready channel interfaces for the ordered set successor table.
// Depends on nothing.
interface osst_req_if;
    logic valid;
    logic ready;
    logic [2:0] kind;
    logic signed [31:0] key;
    modport source (output valid, kind, key, input ready);
    modport sink (input valid, kind, key, output ready);
endinterface

interface osst_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic signed [31:0] result_key;
    logic full_error;
    modport source (output valid, found, result_key, full_error, input ready);
    modport sink (input valid, found, result_key, full_error, output ready);
endinterface

/* sv/ordered_set_successor_table.sv */
// Ordered set of signed keys held sorted in one single-port RAM.
// Queries run a binary search over the stored keys, k <= 11 search steps.
// Insert and delete then shift the entries past the key position, with a read and a write per entry.
// One word is in flight at a time; in_ready is high only when the block is idle.
// Synchronous active-low reset empties the set; RAM contents are not cleared.
module ordered_set_successor_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    osst_req_if.sink        i_req,
    osst_rsp_if.source      o_rsp
);
    import osst_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [31:0] result_key;

    osst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_full_error(o_rsp.full_error),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    osst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_req.kind),
        .i_key       (i_req.key),
        .o_sts       (sts),
        .o_found     (o_rsp.found),
        .o_result_key(result_key)
    );

    assign o_rsp.result_key = result_key;

`ifndef ASSERT_OFF
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("input and output phases overlap");
    a_found_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.result_key == '0))
        else $error("result key nonzero when not found");
    a_full_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.full_error) |-> !o_rsp.found)
        else $error("full error with found");
`endif
endmodule

/* sv/osst_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
module osst_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* sv/osst_dp.sv */
// Datapath: key storage, binary search bounds, shift pointer and entry count.
// Depends on osst_pkg and osst_ram.
module osst_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  osst_pkg::t_cmd        i_cmd,
    input  logic [2:0]            i_kind,
    input  logic [31:0]           i_key,
    output osst_pkg::t_sts        o_sts,
    output logic                  o_found,
    output logic [31:0]           o_result_key
);
    import osst_pkg::*;

    logic [2:0]        r_kind;
    logic [31:0]       r_key;
    logic [CountW-1:0] r_lo, r_hi, r_cnt, r_ptr;
    logic [CountW-1:0] n_lo, n_hi, n_ptr;
    logic [CountW-1:0] mid;
    logic [31:0]       r_carry;
    logic              r_found;
    logic [31:0]       r_res;
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [31:0]       wdata, rdata;
    logic              go_right;
    logic              strict;

    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    assign strict = (r_kind == KIND_NEXT);
    assign go_right = strict ? ((rdata ^ 32'h8000_0000) <= (r_key ^ 32'h8000_0000))
                             : ((rdata ^ 32'h8000_0000) < (r_key ^ 32'h8000_0000));

    always_comb begin
        we = 1'b0;
        addr = mid[AddrW-1:0];
        wdata = r_carry;
        if (i_cmd.fin_rd) begin
            addr = (r_kind == KIND_PREV) ? AddrW'(r_lo - 1'b1) : r_lo[AddrW-1:0];
        end else if (i_cmd.shift_rd) begin
            addr = r_ptr[AddrW-1:0];
        end else if (i_cmd.shift_wr) begin
            we = 1'b1;
            if (r_kind == KIND_INSERT) begin
                addr = r_ptr[AddrW-1:0];
            end else begin
                addr = AddrW'(r_ptr - 1'b1);
                wdata = rdata;
            end
        end else if (i_cmd.wr_key) begin
            we = 1'b1;
            addr = r_lo[AddrW-1:0];
            wdata = r_key;
        end
    end

    osst_ram #(.Width(32), .Depth(Capacity)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        n_ptr = r_ptr;
        if (i_cmd.srch_init) begin
            n_lo = '0;
            n_hi = r_cnt;
        end else if (i_cmd.srch_step) begin
            if (go_right) begin
                n_lo = mid + 1'b1;
            end else begin
                n_hi = mid;
            end
        end
        if (i_cmd.shift_init) begin
            n_ptr = (r_kind == KIND_INSERT) ? r_lo : r_lo + 1'b1;
        end else if (i_cmd.shift_wr) begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key <= i_key;
        end
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_ptr <= n_ptr;
        if (i_cmd.shift_init) begin
            r_carry <= r_key;
        end else if (i_cmd.shift_wr && r_kind == KIND_INSERT) begin
            r_carry <= rdata;
        end
        if (i_cmd.fin_load) begin
            r_found <= 1'b0;
            r_res <= '0;
            unique case (r_kind)
                KIND_EXISTS: r_found <= (r_lo < r_cnt) && (rdata == r_key);
                KIND_NEXT: begin
                    r_found <= (r_lo < r_cnt);
                    r_res <= (r_lo < r_cnt) ? rdata : '0;
                end
                KIND_PREV: begin
                    r_found <= (r_lo != '0);
                    r_res <= (r_lo != '0) ? rdata : '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_sts.srch_done = (r_lo >= r_hi);
    assign o_sts.shift_done = (r_kind == KIND_INSERT) ? (r_ptr >= r_cnt) : (r_ptr >= r_cnt);
    assign o_sts.hit = (r_lo < r_cnt) && (rdata == r_key);
    assign o_sts.full = (r_cnt >= CountW'(Capacity));
    assign o_sts.kind = r_kind;
    assign o_found = r_found;
    assign o_result_key = r_res;
endmodule

/* sv/osst_ctrl.sv */
// Controller state machine sequencing search, shift and result handoff.
// Depends on osst_pkg.
module osst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_full_error,
    input  osst_pkg::t_sts i_sts,
    output osst_pkg::t_cmd o_cmd
);
    import osst_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_RD = 4'd2;
    localparam logic [3:0] S_STEP = 4'd3;
    localparam logic [3:0] S_CHK_RD = 4'd4;
    localparam logic [3:0] S_CHK = 4'd5;
    localparam logic [3:0] S_SH_RD = 4'd6;
    localparam logic [3:0] S_SH_WR = 4'd7;
    localparam logic [3:0] S_FIN = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_full, n_full;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_full_error = r_full;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_full = r_full;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_full = 1'b0;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.srch_done) begin
                    n_state = S_CHK_RD;
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.srch_step = 1'b1;
                n_state = S_RD;
            end
            S_CHK_RD: begin
                o_cmd.fin_rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.fin_load = 1'b1;
                n_state = S_OUT;
                if (i_sts.kind == KIND_INSERT && !i_sts.hit) begin
                    if (i_sts.full) begin
                        n_full = 1'b1;
                    end else begin
                        o_cmd.shift_init = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        n_state = S_FIN;
                    end
                end else if (i_sts.kind == KIND_DELETE && i_sts.hit) begin
                    o_cmd.shift_init = 1'b1;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.shift_done) begin
                    if (i_sts.kind == KIND_DELETE) begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                    n_state = S_OUT;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = S_SH_RD;
            end
            S_FIN: begin
                n_state = S_SH_RD;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full <= n_full;
        end
    end
endmodule

/* test/osst_tb_sb.sv */
// Scoreboard for the ordered set successor table testbench.
// Depends on osst_pkg for the capacity and the request kind codes.
class osst_set_tracker;
    localparam int unsigned Capacity = osst_pkg::Capacity;

    typedef struct packed {
        logic found;
        logic signed [31:0] result_key;
        logic full_error;
    } t_answer;

    logic signed [31:0] keys[$];
    t_answer answers[$];
    int errors;

    function new();
        keys = {};
        answers = {};
        errors = 0;
    endfunction

    // Index of the first stored key >= k, or > k when strict is set.
    function int lower_index(logic signed [31:0] k, bit strict);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = keys.size();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (strict ? (keys[mid] <= k) : (keys[mid] < k)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function void note_request(logic [2:0] kind, logic signed [31:0] k);
        t_answer a;
        int p;
        bit hit;
        a = '0;
        p = lower_index(k, kind == osst_pkg::KIND_NEXT);
        hit = (p < keys.size()) && (keys[p] == k);
        case (kind)
            osst_pkg::KIND_INSERT: begin
                if (!hit) begin
                    if (keys.size() >= Capacity) a.full_error = 1'b1;
                    else keys.insert(p, k);
                end
            end
            osst_pkg::KIND_DELETE: begin
                if (hit) keys.delete(p);
            end
            osst_pkg::KIND_EXISTS: begin
                a.found = hit;
            end
            osst_pkg::KIND_NEXT: begin
                if (p < keys.size()) begin
                    a.found = 1'b1;
                    a.result_key = keys[p];
                end
            end
            osst_pkg::KIND_PREV: begin
                if (p > 0) begin
                    a.found = 1'b1;
                    a.result_key = keys[p - 1];
                end
            end
            default: ;
        endcase
        answers.push_back(a);
    endfunction

    function void check_answer(logic f, logic signed [31:0] rk, logic fe);
        t_answer e;
        if (answers.size() == 0) begin
            $display("%0t: unexpected word found=%0b key=%0d full=%0b", $time, f, rk, fe);
            errors++;
            return;
        end
        e = answers.pop_front();
        if (f !== e.found) begin
            $display("%0t: found expected %0b actual %0b", $time, e.found, f);
            errors++;
        end
        if (rk !== e.result_key) begin
            $display("%0t: result_key expected %0d actual %0d", $time, e.result_key, rk);
            errors++;
        end
        if (fe !== e.full_error) begin
            $display("%0t: full_error expected %0b actual %0b", $time, e.full_error, fe);
            errors++;
        end
    endfunction
endclass

/* test/testbench.sv */
// Top-level testbench for ordered_set_successor_table: directed and random requests,
// checked against a queue-based sorted set. Depends on osst_pkg, osst_if and osst_tb_sb.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import osst_pkg::*;

    logic i_clk;
    logic i_rst_n;
    osst_req_if req_ch();
    osst_rsp_if rsp_ch();
    osst_set_tracker tracker;
    logic signed [31:0] pool[16];
    bit sending;

    ordered_set_successor_table i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [2:0] kind, logic signed [31:0] k);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.key <= k;
        do @(posedge i_clk); while (!req_ch.ready);
        tracker.note_request(kind, k);
    endtask

    function logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return pool[$urandom_range(0, 15)] + $signed($urandom_range(0, 2)) - 1;
        if (r < 7) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom();
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_answer(rsp_ch.found, rsp_ch.result_key, rsp_ch.full_error);
        if (!i_rst_n) rsp_ch.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8) rsp_ch.ready <= ($urandom_range(0, 9) < 2);
        else if (!sending) rsp_ch.ready <= 1'b1;
        else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        #100ms;
        $display("ordered_set_successor_table test failed");
        $finish;
    end

    initial begin
        int wait_cnt;
        logic [2:0] kind;
        tracker = new();
        sending = 1'b1;
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.key = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        for (int i = 0; i < 16; i++) pool[i] = $urandom();
        pool[0] = 32'sh80000000;
        pool[1] = 32'sh7fffffff;
        pool[2] = 0;
        pool[3] = -1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(KIND_NEXT, 0);
        send_word(KIND_PREV, 0);
        send_word(KIND_EXISTS, 32'sh80000000);
        send_word(KIND_DELETE, 5);
        send_word(KIND_INSERT, 32'sh80000000);
        send_word(KIND_INSERT, 32'sh7fffffff);
        send_word(KIND_INSERT, 0);
        send_word(KIND_INSERT, -1);
        send_word(KIND_INSERT, 0);
        send_word(KIND_EXISTS, 0);
        send_word(KIND_EXISTS, 1);
        send_word(KIND_NEXT, 32'sh7fffffff);
        send_word(KIND_NEXT, 32'sh80000000);
        send_word(KIND_NEXT, -1);
        send_word(KIND_PREV, 32'sh80000000);
        send_word(KIND_PREV, 32'sh7fffffff);
        send_word(KIND_PREV, 0);
        send_word(KIND_DELETE, 0);
        send_word(KIND_DELETE, 0);
        send_word(KIND_EXISTS, 0);
        send_word(3'd5, 32'sh5555aaaa);
        send_word(3'd6, 32'shaaaa5555);
        send_word(3'd7, -1);

        for (int i = 0; i < 400; i++) begin
            kind = $urandom_range(0, 99) < 30 ? KIND_INSERT : 3'($urandom_range(1, 4));
            if ($urandom_range(0, 49) == 0) kind = 3'($urandom_range(5, 7));
            send_word(kind, pick_key());
        end

        for (int i = 0; i < 60; i++) send_word(3'($urandom_range(0, 4)), pick_key());
        for (int i = 0; i < 60; i++) begin
            if (tracker.keys.size() == 0) send_word(KIND_DELETE, pick_key());
            else send_word(KIND_DELETE, tracker.keys[$urandom_range(0,
                tracker.keys.size() - 1)]);
        end
        for (int i = 0; i < 40; i++) send_word(3'($urandom_range(2, 4)), pick_key());
        req_ch.valid <= 1'b0;

        sending = 1'b0;
        wait_cnt = 0;
        while (tracker.answers.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.answers.size() == 0)
            $display("ordered_set_successor_table test passed");
        else
            $display("ordered_set_successor_table test failed");
        $finish;
    end
endmodule

/* files.f */
sv/osst_pkg.sv
sv/osst_if.sv
sv/osst_ram.sv
sv/osst_dp.sv
sv/osst_ctrl.sv
sv/ordered_set_successor_table.sv
test/osst_tb_sb.sv
test/testbench.sv
